FILE: hw/rtl/itp_pkg.sv
// ============================================================================
// Infix to postfix package
// Shared types, character constants and operator helpers for the converter.
// ============================================================================
`default_nettype none

package itp_pkg;

    // Operator stack depth and the width of a count that can hold it.
    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // ASCII characters the converter recognises.
    localparam logic [7:0] CH_LPAR  = 8'h28;  // '('
    localparam logic [7:0] CH_RPAR  = 8'h29;  // ')'
    localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CH_MUL   = 8'h2A;  // '*'
    localparam logic [7:0] CH_DIV   = 8'h2F;  // '/'
    localparam logic [7:0] CH_MOD   = 8'h25;  // '%'
    localparam logic [7:0] CH_POW   = 8'h5E;  // '^'
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Stack entry codes.
    typedef logic [2:0] op_code_t;
    localparam op_code_t OP_NONE  = 3'd0;
    localparam op_code_t OP_LPAR  = 3'd1;
    localparam op_code_t OP_PLUS  = 3'd2;
    localparam op_code_t OP_MINUS = 3'd3;
    localparam op_code_t OP_MUL   = 3'd4;
    localparam op_code_t OP_DIV   = 3'd5;
    localparam op_code_t OP_MOD   = 3'd6;
    localparam op_code_t OP_POW   = 3'd7;

    // Error status codes.
    typedef logic [1:0] status_t;
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_UNMATCHED = 2'd1;
    localparam status_t ST_OVERFLOW  = 2'd2;
    localparam status_t ST_UNKNOWN   = 2'd3;

    // Character classes.
    typedef enum logic [2:0] {
        CLS_ALNUM   = 3'd0,
        CLS_LPAR    = 3'd1,
        CLS_RPAR    = 3'd2,
        CLS_OP      = 3'd3,
        CLS_UNKNOWN = 3'd4
    } char_cls_t;

    // Transaction payloads.
    typedef struct packed {
        logic [7:0] token;
        logic       end_of_expr;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       has_char;
        logic       last;
        status_t    status;
    } out_item_t;

    // Command broadcast along the row of stack cells.
    typedef struct packed {
        logic     push;
        logic     pop;
        op_code_t push_code;
    } stack_cmd_t;

    // Maps an operator character to its code; anything else gives OP_NONE.
    function automatic op_code_t f_op_code(input logic [7:0] ch);
        op_code_t code;
        case (ch)
            CH_PLUS:  code = OP_PLUS;
            CH_MINUS: code = OP_MINUS;
            CH_MUL:   code = OP_MUL;
            CH_DIV:   code = OP_DIV;
            CH_MOD:   code = OP_MOD;
            CH_POW:   code = OP_POW;
            default:  code = OP_NONE;
        endcase
        return code;
    endfunction

    // Precedence of a stacked code; '(' ranks lowest so nothing pops past it.
    function automatic logic [1:0] f_prec(input op_code_t code);
        logic [1:0] prec;
        case (code) inside
            OP_PLUS, OP_MINUS:       prec = 2'd1;
            OP_MUL, OP_DIV, OP_MOD:  prec = 2'd2;
            OP_POW:                  prec = 2'd3;
            default:                 prec = 2'd0;
        endcase
        return prec;
    endfunction

    // Character emitted when a code is popped.
    function automatic logic [7:0] f_code_char(input op_code_t code);
        logic [7:0] ch;
        case (code)
            OP_LPAR:  ch = CH_LPAR;
            OP_PLUS:  ch = CH_PLUS;
            OP_MINUS: ch = CH_MINUS;
            OP_MUL:   ch = CH_MUL;
            OP_DIV:   ch = CH_DIV;
            OP_MOD:   ch = CH_MOD;
            OP_POW:   ch = CH_POW;
            default:  ch = CH_NUL;
        endcase
        return ch;
    endfunction

    // Sorts an input character into its class.
    function automatic char_cls_t f_classify(input logic [7:0] ch);
        char_cls_t cls;
        if ((ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h5A) ||
            (ch >= 8'h61 && ch <= 8'h7A)) begin
            cls = CLS_ALNUM;
        end else if (ch == CH_LPAR) begin
            cls = CLS_LPAR;
        end else if (ch == CH_RPAR) begin
            cls = CLS_RPAR;
        end else if (f_op_code(ch) != OP_NONE) begin
            cls = CLS_OP;
        end else begin
            cls = CLS_UNKNOWN;
        end
        return cls;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/itp_cell.sv
// ============================================================================
// Operator stack cell
// One entry of the shifting operator stack; takes its upper neighbour on a
// push and its lower neighbour on a pop.
// ============================================================================
`default_nettype none

module itp_cell (
    input  wire                  aclk,
    input  itp_pkg::stack_cmd_t  cmd,
    input  itp_pkg::op_code_t    prev_code,
    input  itp_pkg::op_code_t    next_code,
    output itp_pkg::op_code_t    code
);
    import itp_pkg::*;

    op_code_t code_reg;

    // Shift towards the bottom on a push, towards the top on a pop.
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            code_reg <= prev_code;
        end else if (cmd.pop) begin
            code_reg <= next_code;
        end
    end

    assign code = code_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/itp_ctrl.sv
// ============================================================================
// Infix to postfix sequencer
// Classifies each character, drives pushes and pops of the cell row, and
// holds the result register towards the output channel.
// ============================================================================
`default_nettype none

module itp_ctrl (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  itp_pkg::in_item_t     s_data,
    output logic                  m_valid,
    input  wire                   m_ready,
    output itp_pkg::out_item_t    m_data,
    input  itp_pkg::op_code_t     cell_code [itp_pkg::STACK_DEPTH],
    output itp_pkg::stack_cmd_t   cmd
);
    import itp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CHAR  = 3'b010,
        S_FLUSH = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    char_cls_t        cls_reg;
    logic [7:0]       tok_reg;
    op_code_t         code_reg;
    logic             end_reg;
    logic             emitted_reg;
    status_t          error_seen_reg, error_seen_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg;
    out_item_t        m_data_reg;

    logic             accept;
    logic             empty, full, count_one;
    logic             lpar_found;
    logic             slot_free;
    op_code_t         top_code;
    char_cls_t        in_cls;
    op_code_t         in_code;
    status_t          step_err;
    logic             emit, emit_has, emit_last;
    logic [7:0]       emit_char;
    logic             finish;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign top_code  = cell_code[0];
    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNT_W'(STACK_DEPTH));
    assign count_one = (count_reg == CNT_W'(1));
    assign slot_free = !m_valid_reg || m_ready;
    assign in_cls    = f_classify(s_data.token);
    assign in_code   = f_op_code(s_data.token);

    // Look for a '(' among the occupied cells.
    always_comb begin
        lpar_found = 1'b0;
        for (int i = 0; i < STACK_DEPTH; i++) begin
            if ((CNT_W'(i) < count_reg) && (cell_code[i] == OP_LPAR)) begin
                lpar_found = 1'b1;
            end
        end
    end

    // The error a character raises is known before any pop takes place.
    always_comb begin
        step_err = ST_OK;
        case (in_cls)
            CLS_UNKNOWN: step_err = ST_UNKNOWN;
            CLS_LPAR:    step_err = full ? ST_OVERFLOW : ST_OK;
            CLS_RPAR:    step_err = lpar_found ? ST_OK : ST_UNMATCHED;
            CLS_OP: begin
                if (full && (f_prec(top_code) < f_prec(in_code))) begin
                    step_err = ST_OVERFLOW;
                end
            end
            default:     step_err = ST_OK;
        endcase
    end

    // Sequencer: at most one push or pop and one emitted result per cycle.
    always_comb begin
        state_next      = state_reg;
        error_seen_next = error_seen_reg;
        cmd.push        = 1'b0;
        cmd.pop         = 1'b0;
        cmd.push_code   = (cls_reg == CLS_LPAR) ? OP_LPAR : code_reg;
        emit            = 1'b0;
        emit_char       = f_code_char(top_code);
        emit_has        = 1'b1;
        emit_last       = 1'b0;
        finish          = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_CHAR;
                    if (error_seen_reg == ST_OK) begin
                        error_seen_next = step_err;
                    end
                end
            end
            S_CHAR: begin
                case (cls_reg)
                    CLS_ALNUM: begin
                        if (slot_free) begin
                            emit      = 1'b1;
                            emit_char = tok_reg;
                            emit_last = end_reg && empty;
                            finish    = 1'b1;
                        end
                    end
                    CLS_LPAR: begin
                        cmd.push = !full;
                        finish   = 1'b1;
                    end
                    CLS_RPAR: begin
                        if (empty) begin
                            finish = 1'b1;
                        end else if (top_code == OP_LPAR) begin
                            cmd.pop = 1'b1;
                            finish  = 1'b1;
                        end else if (slot_free) begin
                            // Last when the stack empties, either now or once
                            // the matching '(' right below is discarded.
                            emit      = 1'b1;
                            emit_last = end_reg && (count_one ||
                                        ((count_reg == CNT_W'(2)) &&
                                         (cell_code[1] == OP_LPAR)));
                            cmd.pop   = 1'b1;
                        end
                    end
                    CLS_OP: begin
                        if (!empty && (f_prec(top_code) >= f_prec(code_reg))) begin
                            if (slot_free) begin
                                emit    = 1'b1;
                                cmd.pop = 1'b1;
                            end
                        end else begin
                            cmd.push = !full;
                            finish   = 1'b1;
                        end
                    end
                    default: begin
                        finish = 1'b1;
                    end
                endcase
                if (finish) begin
                    state_next = end_reg ? S_FLUSH : S_IDLE;
                end
            end
            S_FLUSH: begin
                if (!empty) begin
                    if (slot_free) begin
                        emit      = 1'b1;
                        emit_last = count_one;
                        cmd.pop   = 1'b1;
                    end
                end else if (emitted_reg || slot_free) begin
                    // A bare end marker goes out when nothing else was emitted for the final character.
                    emit            = !emitted_reg;
                    emit_char       = CH_NUL;
                    emit_has        = 1'b0;
                    emit_last       = 1'b1;
                    error_seen_next = ST_OK;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Stack occupancy.
    always_comb begin
        count_next = count_reg;
        if (cmd.push) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            error_seen_reg <= ST_OK;
            emitted_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            error_seen_reg <= error_seen_next;
            if (accept) begin
                emitted_reg <= 1'b0;
            end else if (emit) begin
                emitted_reg <= 1'b1;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Latched character and result payload.
    always_ff @(posedge aclk) begin
        if (accept) begin
            cls_reg  <= in_cls;
            tok_reg  <= s_data.token;
            code_reg <= in_code;
            end_reg  <= s_data.end_of_expr;
        end
        if (emit) begin
            m_data_reg.out_char <= emit_char;
            m_data_reg.has_char <= emit_has;
            m_data_reg.last     <= emit_last;
            m_data_reg.status   <= error_seen_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    // A pop is never issued against an empty stack.
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> (count_reg != '0))
        else $error("pop issued on an empty operator stack");

    // A result is only loaded when the output register is free or draining.
    a_emit_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten before it was taken");

    // The end of an expression leaves an empty stack and a clear error.
    a_end_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FLUSH && state_next == S_IDLE)
            |=> (count_reg == '0 && error_seen_reg == ST_OK))
        else $error("stack or error not cleared at end of expression");

    // The stack never grows beyond its depth.
    a_no_overgrow: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> (count_reg != CNT_W'(STACK_DEPTH)))
        else $error("push issued on a full operator stack");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/infix_to_postfix_converter.sv
// ============================================================================
// Infix to postfix converter
// Shunting-yard conversion of an ASCII infix stream into postfix characters.
// ============================================================================
// One input transaction carries one character, taken only while the
// sequencer is idle; each character is accepted and then handled, popping
// from the stack each operator that it displaces, and the final character
// of an expression then flushes the remaining operators and closes the
// expression. The sequencer makes at most one push or pop and one emitted
// result per cycle on a shifting stack of cells whose top is always cell 0;
// stalls on the result channel hold it. Errors are sticky per expression
// and every result of a character carries the status after that character.
`default_nettype none

module infix_to_postfix_converter (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  itp_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output itp_pkg::out_item_t  m_data
);
    import itp_pkg::*;

    stack_cmd_t cmd;
    op_code_t   cell_code [STACK_DEPTH];

    // Sequencer and result register.
    itp_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cell_code (cell_code),
        .cmd       (cmd)
    );

    // Row of stack cells; each takes its neighbour's code on a shift.
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        op_code_t prev_code;
        op_code_t next_code;

        if (i == 0) begin : g_top
            assign prev_code = cmd.push_code;
        end else begin : g_mid
            assign prev_code = cell_code[i-1];
        end

        if (i == STACK_DEPTH - 1) begin : g_bottom
            assign next_code = OP_NONE;
        end else begin : g_inner
            assign next_code = cell_code[i+1];
        end

        itp_cell u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .prev_code (prev_code),
            .next_code (next_code),
            .code      (cell_code[i])
        );
    end

endmodule

`default_nettype wire
